// ----- rtl/jcu_pkg.sv -----
// Shared types, constants and helpers for the chroma upsample / MCU assembly block.
`timescale 1ns / 1ps

package jcu_pkg;

    localparam int SMP_W     = 8;
    localparam int NSMP      = 8;
    localparam int ROW_W     = SMP_W * NSMP;
    localparam int HALF      = NSMP / 2;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int ROWS      = 8;
    localparam int ROW_IDX_W = 3;
    localparam int BLK_W     = 2;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;
    localparam int IDX_W     = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_H  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_V  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_H = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_V = 2'd3;

    // command kinds
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_COPY  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HDBL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HVDBL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_JOIN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERR   = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  stored;
    } cmd_t;

    // samples 0..3 each doubled
    function automatic logic [ROW_W-1:0] dbl_left(input logic [ROW_W-1:0] r);
        logic [ROW_W-1:0] o;
        o = '0;
        for (int i = 0; i < HALF; i++)
        begin
            o[(2*i)*SMP_W +: SMP_W]   = r[i*SMP_W +: SMP_W];
            o[(2*i+1)*SMP_W +: SMP_W] = r[i*SMP_W +: SMP_W];
        end
        return o;
    endfunction

    // samples 4..7 each doubled
    function automatic logic [ROW_W-1:0] dbl_right(input logic [ROW_W-1:0] r);
        logic [ROW_W-1:0] o;
        o = '0;
        for (int i = 0; i < HALF; i++)
        begin
            o[(2*i)*SMP_W +: SMP_W]   = r[(i+HALF)*SMP_W +: SMP_W];
            o[(2*i+1)*SMP_W +: SMP_W] = r[(i+HALF)*SMP_W +: SMP_W];
        end
        return o;
    endfunction

endpackage

// ----- rtl/jpeg_chroma_upsample_mcu_assemble_top.sv -----
// A request's half-rows pass the command queue, then the output register, to m_tvalid.
// One half-row per cycle while m_tready is high and a command waits; a row gives 1
//   half-row (copy, error), 2 (4:2:2, join) or 4 (4:2:0) through one output register.
// First block of a join pair stores its rows and produces nothing.
// Reset (rst_n low, async): registers back to 1, counters and queue cleared, row store kept.
`timescale 1ns / 1ps

module jpeg_chroma_upsample_mcu_assemble_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jcu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jcu_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [jcu_pkg::ROW_W-1:0]     s_tdata,   // sample0..sample7, 8 bits each
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [jcu_pkg::ROW_W-1:0]     m_tdata,   // pix0..pix7, 8 bits each
    output logic                          m_tlast,   // end_of_unit
    output logic                          m_tuser    // format_error
);

    logic          q_full, q_push, q_pop, head_valid;
    jcu_pkg::cmd_t q_cmd, head_cmd;

    jcu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    jcu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    jcu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ----- rtl/jcu_front.sv -----
// Front end: config registers, format decode, row/block counters, first-block row store.
`timescale 1ns / 1ps

module jcu_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jcu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jcu_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [jcu_pkg::ROW_W-1:0]     s_tdata,
    input  logic                          q_full,
    output logic                          q_push,
    output jcu_pkg::cmd_t                 q_cmd
);

    logic [jcu_pkg::CFG_W-1:0]     in_h_reg, in_v_reg, out_h_reg, out_v_reg;
    logic [jcu_pkg::ROW_IDX_W-1:0] row_cnt_reg, row_cnt_next;
    logic [jcu_pkg::BLK_W-1:0]     blk_cnt_reg, blk_cnt_next;
    logic [jcu_pkg::ROW_W-1:0]     store_reg [jcu_pkg::ROWS];

    logic [jcu_pkg::CFG_W:0] in_h2, in_v2, out_h4, out_v4;
    logic is_copy, is_hd, is_hvd, same, is_j21, is_j22, is_join;
    logic last_row, accept, store_wr;
    logic [jcu_pkg::KIND_W-1:0] kind;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    assign in_h2  = {in_h_reg, 1'b0};
    assign in_v2  = {in_v_reg, 1'b0};
    assign out_h4 = {1'b0, out_h_reg};
    assign out_v4 = {1'b0, out_v_reg};

    assign is_copy = (out_h_reg == 3'd1) && (out_v_reg == 3'd1);
    assign is_hd   = (in_h2 == out_h4) && (in_v_reg == out_v_reg);
    assign is_hvd  = (in_h2 == out_h4) && (in_v2 == out_v4);
    assign same    = (in_h_reg == out_h_reg) && (in_v_reg == out_v_reg);
    assign is_j21  = same && (out_h_reg == 3'd2) && (out_v_reg == 3'd1);
    assign is_j22  = same && (out_h_reg == 3'd2) && (out_v_reg == 3'd2);

    always_comb
    begin
        if (is_copy)
            kind = jcu_pkg::KIND_COPY;
        else if (is_hd)
            kind = jcu_pkg::KIND_HDBL;
        else if (is_hvd)
            kind = jcu_pkg::KIND_HVDBL;
        else if (is_j21 || is_j22)
            kind = jcu_pkg::KIND_JOIN;
        else
            kind = jcu_pkg::KIND_ERR;
    end

    assign is_join  = (kind == jcu_pkg::KIND_JOIN);
    assign last_row = (row_cnt_reg == 3'd7);
    assign store_wr = accept && is_join && !blk_cnt_reg[0];
    assign q_push   = accept && !(is_join && !blk_cnt_reg[0]);

    always_comb
    begin
        q_cmd.kind   = kind;
        q_cmd.row    = s_tdata;
        q_cmd.stored = store_reg[row_cnt_reg];
        if (kind == jcu_pkg::KIND_ERR)
            q_cmd.last = 1'b0;
        else if (is_join)
            q_cmd.last = last_row && (is_j21 || (blk_cnt_reg == 2'd3));
        else
            q_cmd.last = last_row;
    end

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        blk_cnt_next = blk_cnt_reg;
        if (accept && (kind != jcu_pkg::KIND_ERR))
        begin
            row_cnt_next = row_cnt_reg + 3'd1;
            if (last_row && is_join)
                blk_cnt_next = blk_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_h_reg    <= 3'd1;
            in_v_reg    <= 3'd1;
            out_h_reg   <= 3'd1;
            out_v_reg   <= 3'd1;
            row_cnt_reg <= '0;
            blk_cnt_reg <= '0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            blk_cnt_reg <= blk_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    jcu_pkg::REG_IN_H:  in_h_reg  <= cfg_data;
                    jcu_pkg::REG_IN_V:  in_v_reg  <= cfg_data;
                    jcu_pkg::REG_OUT_H: out_h_reg <= cfg_data;
                    jcu_pkg::REG_OUT_V: out_v_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
            store_reg[row_cnt_reg] <= s_tdata;
    end

endmodule

// ----- rtl/jcu_queue.sv -----
// Two-entry command queue between front and back.
`timescale 1ns / 1ps

module jcu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jcu_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output jcu_pkg::cmd_t head_cmd
);

    jcu_pkg::cmd_t                 q_reg [jcu_pkg::Q_DEPTH];
    logic [jcu_pkg::Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [jcu_pkg::Q_CNT_W-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == jcu_pkg::Q_CNT_W'(jcu_pkg::Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = q_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- rtl/jcu_back.sv -----
// Back end: expands one command into 1, 2 or 4 half-rows through an output register.
`timescale 1ns / 1ps

module jcu_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  jcu_pkg::cmd_t             head_cmd,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [jcu_pkg::ROW_W-1:0] m_tdata,
    output logic                      m_tlast,
    output logic                      m_tuser
);

    logic [jcu_pkg::IDX_W-1:0] idx_reg, idx_next, last_idx;
    logic                      vld_reg;
    logic [jcu_pkg::ROW_W-1:0] pix_reg, pix;
    logic                      eou_reg, eou, err_reg, err;
    logic                      load;

    always_comb
    begin
        pix = '0;
        eou = 1'b0;
        err = 1'b0;
        unique case (head_cmd.kind)
            jcu_pkg::KIND_COPY:
            begin
                last_idx = 2'd0;
                pix      = head_cmd.row;
                eou      = head_cmd.last;
            end
            jcu_pkg::KIND_HDBL:
            begin
                last_idx = 2'd1;
                pix      = idx_reg[0] ? jcu_pkg::dbl_right(head_cmd.row)
                                      : jcu_pkg::dbl_left(head_cmd.row);
                eou      = head_cmd.last && (idx_reg == last_idx);
            end
            jcu_pkg::KIND_HVDBL:
            begin
                last_idx = 2'd3;
                pix      = idx_reg[0] ? jcu_pkg::dbl_right(head_cmd.row)
                                      : jcu_pkg::dbl_left(head_cmd.row);
                eou      = head_cmd.last && (idx_reg == last_idx);
            end
            jcu_pkg::KIND_JOIN:
            begin
                last_idx = 2'd1;
                pix      = idx_reg[0] ? head_cmd.row : head_cmd.stored;
                eou      = head_cmd.last && (idx_reg == last_idx);
            end
            default:
            begin
                last_idx = 2'd0;
                err      = 1'b1;
            end
        endcase
    end

    assign load     = head_valid && (!vld_reg || m_tready);
    assign pop      = load && (idx_reg == last_idx);
    assign idx_next = pop ? '0 : (load ? idx_reg + 2'd1 : idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                vld_reg <= 1'b1;
            else if (m_tready)
                vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg <= pix;
            eou_reg <= eou;
            err_reg <= err;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = pix_reg;
    assign m_tlast  = eou_reg;
    assign m_tuser  = err_reg;

endmodule

// ----- rtl/jcu_checker.sv -----
// Port-level checks for the chroma upsample / MCU assembly block.
`timescale 1ns / 1ps

module jcu_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [jcu_pkg::ROW_W-1:0] m_tdata,
    input logic                      m_tlast,
    input logic                      m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    a_err_no_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tlast)
        else $error("error item marked end of unit");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == '0))
        else $error("error item carries nonzero samples");

endmodule

bind jpeg_chroma_upsample_mcu_assemble_top jcu_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/jpeg_chroma_upsample_mcu_assemble_top_tb.sv -----
// Testbench for the chroma upsample / MCU assembly block: predicts half-rows and checks them.
`timescale 1ns / 1ps

module jpeg_chroma_upsample_mcu_assemble_top_tb;

    typedef logic [jcu_pkg::ROW_W-1:0] row_t;

    typedef enum logic [2:0] {
        FMT_COPY,
        FMT_HDBL,
        FMT_HVDBL,
        FMT_JOIN_2X1,
        FMT_JOIN_2X2,
        FMT_BAD
    } fmt_t;

    typedef struct packed {
        row_t pix;
        logic eou;
        logic err;
    } half_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [jcu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [jcu_pkg::CFG_W-1:0]     cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    row_t                          s_tdata;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    row_t                          m_tdata;
    logic                          m_tlast;
    logic                          m_tuser;

    // shadow of the block's registers and counters
    logic [jcu_pkg::CFG_W-1:0]     sh_in_h = 3'd1;
    logic [jcu_pkg::CFG_W-1:0]     sh_in_v = 3'd1;
    logic [jcu_pkg::CFG_W-1:0]     sh_out_h = 3'd1;
    logic [jcu_pkg::CFG_W-1:0]     sh_out_v = 3'd1;
    row_t                          first_rows [jcu_pkg::ROWS];
    logic [jcu_pkg::ROW_IDX_W-1:0] row_idx = '0;
    logic [jcu_pkg::BLK_W-1:0]     blk_idx = '0;

    half_row_t pending_rows [$];
    int        mismatches = 0;
    int        src_idle = 0;
    int        sink_idle = 0;

    jpeg_chroma_upsample_mcu_assemble_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #6 clk = ~clk;

    function automatic fmt_t classify_format();
        int ih;
        int iv;
        int oh;
        int ov;
        ih = sh_in_h;
        iv = sh_in_v;
        oh = sh_out_h;
        ov = sh_out_v;
        if (oh == 1 && ov == 1)
            return FMT_COPY;
        if (2 * ih == oh && iv == ov)
            return FMT_HDBL;
        if (2 * ih == oh && 2 * iv == ov)
            return FMT_HVDBL;
        if (ih == oh && iv == ov && oh == 2 && ov == 1)
            return FMT_JOIN_2X1;
        if (ih == oh && iv == ov && oh == 2 && ov == 2)
            return FMT_JOIN_2X2;
        return FMT_BAD;
    endfunction

    function automatic void queue_half(input row_t pix, input logic eou, input logic err);
        half_row_t h;
        h.pix = pix;
        h.eou = eou;
        h.err = err;
        pending_rows.push_back(h);
    endfunction

    // expected half-rows for one accepted row request
    function automatic void upsample_row(input row_t row);
        row_t lo;
        row_t hi;
        logic last_row;
        fmt_t fmt;
        fmt = classify_format();
        last_row = (row_idx == 3'd7);
        for (int i = 0; i < jcu_pkg::HALF; i++)
        begin
            lo[16*i +: 8]     = row[8*i +: 8];
            lo[16*i + 8 +: 8] = row[8*i +: 8];
            hi[16*i +: 8]     = row[8*(i+4) +: 8];
            hi[16*i + 8 +: 8] = row[8*(i+4) +: 8];
        end
        case (fmt)
            FMT_BAD:
            begin
                queue_half('0, 1'b0, 1'b1);
                return;
            end
            FMT_COPY:
                queue_half(row, last_row, 1'b0);
            FMT_HDBL:
            begin
                queue_half(lo, 1'b0, 1'b0);
                queue_half(hi, last_row, 1'b0);
            end
            FMT_HVDBL:
            begin
                queue_half(lo, 1'b0, 1'b0);
                queue_half(hi, 1'b0, 1'b0);
                queue_half(lo, 1'b0, 1'b0);
                queue_half(hi, last_row, 1'b0);
            end
            default:
            begin
                if (!blk_idx[0])
                    first_rows[row_idx] = row;
                else
                begin
                    queue_half(first_rows[row_idx], 1'b0, 1'b0);
                    queue_half(row, last_row && (fmt == FMT_JOIN_2X1 || blk_idx == 2'd3),
                               1'b0);
                end
            end
        endcase
        if (last_row && (fmt == FMT_JOIN_2X1 || fmt == FMT_JOIN_2X2))
            blk_idx = blk_idx + 2'd1;
        row_idx = row_idx + 3'd1;
    endfunction

    task automatic report_mismatch(input string what, input row_t want, input row_t got);
        mismatches++;
        $display("%0t: %s want %0h got %0h", $time, what, want, got);
    endtask

    task automatic check_half();
        half_row_t want;
        if (pending_rows.size() == 0)
        begin
            report_mismatch("unexpected half-row", '0, m_tdata);
            return;
        end
        want = pending_rows.pop_front();
        for (int i = 0; i < jcu_pkg::NSMP; i++)
            if (m_tdata[8*i +: 8] !== want.pix[8*i +: 8])
                report_mismatch($sformatf("pix%0d", i), row_t'(want.pix[8*i +: 8]),
                                row_t'(m_tdata[8*i +: 8]));
        if (m_tlast !== want.eou)
            report_mismatch("end_of_unit", row_t'(want.eou), row_t'(m_tlast));
        if (m_tuser !== want.err)
            report_mismatch("format_error", row_t'(want.err), row_t'(m_tuser));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_half();
            m_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    task automatic send_row(input row_t row);
        if ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        upsample_row(row);
    endtask

    // all requests answered, then room for rows still held in the pipe
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [jcu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [jcu_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            jcu_pkg::REG_IN_H:  sh_in_h = val;
            jcu_pkg::REG_IN_V:  sh_in_v = val;
            jcu_pkg::REG_OUT_H: sh_out_h = val;
            default:            sh_out_v = val;
        endcase
    endtask

    task automatic set_format(input logic [jcu_pkg::CFG_W-1:0] ih,
                              input logic [jcu_pkg::CFG_W-1:0] iv,
                              input logic [jcu_pkg::CFG_W-1:0] oh,
                              input logic [jcu_pkg::CFG_W-1:0] ov);
        wait_idle();
        write_reg(jcu_pkg::REG_IN_H, ih);
        write_reg(jcu_pkg::REG_IN_V, iv);
        write_reg(jcu_pkg::REG_OUT_H, oh);
        write_reg(jcu_pkg::REG_OUT_V, ov);
        cfg_valid <= 1'b0;
    endtask

    function automatic row_t pattern_row(input int k);
        row_t r;
        case (k % 8)
            0:       r = '0;
            1:       r = '1;
            2:       r = 64'h0706050403020100;
            3:       r = 64'h55AA55AA55AA55AA;
            4:       r = 64'hAA55AA55AA55AA55;
            5:       r = 64'h8040201008040201;
            6:       r = 64'h7FBFDFEFF7FBFDFE;
            default: r = 64'hFEDCBA9876543210;
        endcase
        return (k >= 8) ? ~r : r;
    endfunction

    function automatic row_t random_row();
        row_t r;
        for (int i = 0; i < jcu_pkg::NSMP; i++)
        begin
            case ($urandom_range(7))
                0:       r[8*i +: 8] = 8'h00;
                1:       r[8*i +: 8] = 8'hFF;
                default: r[8*i +: 8] = 8'($urandom);
            endcase
        end
        return r;
    endfunction

    // first test after reset: fills the whole row store before any join reads it
    task automatic test_join_store();
        set_format(3'd2, 3'd1, 3'd2, 3'd1);
        for (int k = 0; k < 16; k++)
            send_row(pattern_row(k));
    endtask

    task automatic test_stream_modes();
        set_format(3'd4, 3'd4, 3'd1, 3'd1);
        send_row(pattern_row(1));
        send_row(pattern_row(7));
        set_format(3'd2, 3'd4, 3'd4, 3'd4);
        send_row(pattern_row(2));
        send_row(pattern_row(13));
        set_format(3'd1, 3'd1, 3'd2, 3'd2);
        send_row(pattern_row(3));
        send_row(pattern_row(8));
    endtask

    task automatic test_format_errors();
        set_format(3'd4, 3'd4, 3'd4, 3'd4);
        send_row(pattern_row(9));
        set_format(3'd1, 3'd4, 3'd1, 3'd4);
        send_row(pattern_row(5));
        set_format(3'd1, 3'd1, 3'd3, 3'd1);
        send_row(pattern_row(6));
    endtask

    task automatic pick_format();
        logic [jcu_pkg::CFG_W-1:0] ih;
        logic [jcu_pkg::CFG_W-1:0] iv;
        ih = 3'($urandom_range(2, 1));
        iv = 3'($urandom_range(2, 1));
        case ($urandom_range(9))
            0, 1:    set_format(3'($urandom_range(4, 1)), 3'($urandom_range(4, 1)), 3'd1, 3'd1);
            2, 3:
            begin
                iv = 3'($urandom_range(4, 1));
                set_format(ih, iv, 3'(2 * ih), iv);
            end
            4, 5:    set_format(ih, iv, 3'(2 * ih), 3'(2 * iv));
            6:       set_format(3'd2, 3'd1, 3'd2, 3'd1);
            7:       set_format(3'd2, 3'd2, 3'd2, 3'd2);
            default: set_format(3'($urandom_range(4, 1)), 3'($urandom_range(4, 1)),
                                3'($urandom_range(4, 1)), 3'($urandom_range(4, 1)));
        endcase
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_rows);
        int sent;
        int seg;
        src_idle  = src_pct;
        sink_idle = sink_pct;
        sent = 0;
        while (sent < n_rows)
        begin
            pick_format();
            seg = $urandom_range(40, 8);
            if (seg > n_rows - sent)
                seg = n_rows - sent;
            repeat (seg) send_row(random_row());
            sent += seg;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        src_idle  = 22;
        sink_idle = 66;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_join_store();
        test_stream_modes();
        test_format_errors();
        test_random_traffic(22, 66, 120);
        test_random_traffic(66, 22, 120);
        test_random_traffic(0, 0, 120);
        wait_idle();
        if (mismatches == 0)
            $display("jpeg_chroma_upsample_mcu_assemble_top_tb OK");
        else
            $display("jpeg_chroma_upsample_mcu_assemble_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("jpeg_chroma_upsample_mcu_assemble_top_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/jcu_pkg.sv
rtl/jcu_front.sv
rtl/jcu_queue.sv
rtl/jcu_back.sv
rtl/jpeg_chroma_upsample_mcu_assemble_top.sv
rtl/jcu_checker.sv
tb/sv/jpeg_chroma_upsample_mcu_assemble_top_tb.sv
